@@ rtl/mfcps_pkg.sv @@
// shared types, constants and crc helper for the paced modbus frame sender
// no dependencies; imported by every module of the block except mfcps_ram
package mfcps_pkg;

  // queue geometry
  localparam int MAIN_DEPTH  = 5;
  localparam int LOW_DEPTH   = 3;
  localparam int MAX_PAYLOAD = 62;
  localparam int SLOT_BYTES  = 64;
  localparam int IDX_W       = 6;
  localparam int BCNT_W      = 7;
  localparam int LEN_W       = 7;
  localparam int NUM_SLOTS   = MAIN_DEPTH + LOW_DEPTH;
  localparam int LEN_IW      = $clog2(NUM_SLOTS);
  localparam int MAIN_SW     = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
  localparam int LOW_SW      = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
  localparam int MAIN_CW     = $clog2(MAIN_DEPTH + 1);
  localparam int LOW_CW      = $clog2(LOW_DEPTH + 1);
  localparam int MAIN_AW     = $clog2(MAIN_DEPTH * SLOT_BYTES);
  localparam int LOW_AW      = $clog2(LOW_DEPTH * SLOT_BYTES);
  localparam int SUM_W       = 6;

  // crc and timing constants
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;
  localparam logic [15:0] MAIN_GAP_RST = 16'd1000;
  localparam logic [15:0] LOW_GAP_RST  = 16'd100;

  // register indexes
  localparam logic REG_MAIN_GAP = 1'b0;
  localparam logic REG_LOW_GAP  = 1'b1;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    RES_QUEUED  = 2'd0,
    RES_DROPPED = 2'd1,
    RES_TX      = 2'd2
  } result_kind_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       low_priority;
  } in_item_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [7:0]   tx_byte;
    logic         from_low_queue;
    logic         last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_POST,
    ST_SEND_RD,
    ST_SEND_OUT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic take_tick;
    logic copy_rd;
    logic copy_wr;
    logic crc_lo;
    logic crc_hi;
    logic post;
    logic send_rd;
    logic send_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_ok;
    logic copy_last;
    logic tick_go;
    logic out_free;
    logic send_last;
  } status_t;

  // one byte of modbus crc-16, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/mfcps_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module mfcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/mfcps_dp.sv @@
// datapath: build buffer, frame stores, queue pointers, crc, pacing timer, output register
// depends on mfcps_pkg and mfcps_ram
module mfcps_dp
  import mfcps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  in_item_t    in_data_i,
  input  logic [15:0] main_gap_i,
  input  logic [15:0] low_gap_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output out_item_t   out_data_o
);

  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic               ovf_q, ovf_d;
  logic [15:0]        crc_q, crc_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               sel_low_q, sel_low_d;
  logic               ok_q, ok_d;
  logic [MAIN_SW-1:0] main_head_q, main_head_d;
  logic [MAIN_CW-1:0] main_cnt_q, main_cnt_d;
  logic [LOW_SW-1:0]  low_head_q, low_head_d;
  logic [LOW_CW-1:0]  low_cnt_q, low_cnt_d;
  logic [15:0]        elapsed_q, elapsed_d;
  logic               rdy_q, rdy_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic [LEN_W-1:0]   len_q [NUM_SLOTS];

  logic [SUM_W-1:0]   main_sum, low_sum;
  logic [MAIN_SW-1:0] main_tail;
  logic [LOW_SW-1:0]  low_tail;
  logic [LEN_IW-1:0]  len_rd_idx, len_wr_idx;
  logic [LEN_W-1:0]   len_rd;
  logic [15:0]        el_next;
  logic               rdy_next, go, go_low;
  logic               store_wr;
  logic [7:0]         store_wdata, buf_rdata, main_rdata, low_rdata;
  logic               buf_room;

  // tail slots: head plus count, wrapped once
  assign main_sum  = SUM_W'(main_head_q) + SUM_W'(main_cnt_q);
  assign low_sum   = SUM_W'(low_head_q) + SUM_W'(low_cnt_q);
  assign main_tail = MAIN_SW'((main_sum >= SUM_W'(MAIN_DEPTH)) ?
                              main_sum - SUM_W'(MAIN_DEPTH) : main_sum);
  assign low_tail  = LOW_SW'((low_sum >= SUM_W'(LOW_DEPTH)) ?
                             low_sum - SUM_W'(LOW_DEPTH) : low_sum);

  // frame length table lookups
  assign len_rd_idx = LEN_IW'(sel_low_q ? MAIN_DEPTH + int'(low_head_q) : int'(main_head_q));
  assign len_wr_idx = LEN_IW'(sel_low_q ? MAIN_DEPTH + int'(low_tail) : int'(main_tail));
  assign len_rd     = len_q[len_rd_idx];

  assign buf_room = (bcnt_q < BCNT_W'(MAX_PAYLOAD));

  // pacing decision for a tick
  always_comb begin
    el_next  = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
    rdy_next = rdy_q;
    go       = 1'b0;
    go_low   = 1'b0;
    if (main_cnt_q != '0) begin
      rdy_next = rdy_q | (el_next > main_gap_i);
      go       = rdy_next;
    end else if (low_cnt_q != '0) begin
      rdy_next = rdy_q | (el_next > low_gap_i);
      go       = rdy_next;
      go_low   = 1'b1;
    end
  end

  // status toward the controller
  always_comb begin
    status_o.frame_ok  = !(ovf_q || !buf_room) &&
                         (in_data_i.low_priority ? (low_cnt_q < LOW_CW'(LOW_DEPTH))
                                                 : (main_cnt_q < MAIN_CW'(MAIN_DEPTH)));
    status_o.copy_last = (BCNT_W'(idx_q) + BCNT_W'(1)) == bcnt_q;
    status_o.tick_go   = go;
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.send_last = (LEN_W'(idx_q) + LEN_W'(1)) == len_rd;
  end

  // store write data mux
  assign store_wr    = cmd_i.copy_wr || cmd_i.crc_lo || cmd_i.crc_hi;
  assign store_wdata = cmd_i.copy_wr ? buf_rdata : (cmd_i.crc_lo ? crc_q[7:0] : crc_q[15:8]);

  // next state of the datapath registers
  always_comb begin
    bcnt_d      = bcnt_q;
    ovf_d       = ovf_q;
    crc_d       = crc_q;
    idx_d       = idx_q;
    sel_low_d   = sel_low_q;
    ok_d        = ok_q;
    main_head_d = main_head_q;
    main_cnt_d  = main_cnt_q;
    low_head_d  = low_head_q;
    low_cnt_d   = low_cnt_q;
    elapsed_d   = elapsed_q;
    rdy_d       = rdy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cmd_i.take_byte) begin
      if (buf_room) begin
        bcnt_d = bcnt_q + BCNT_W'(1);
        crc_d  = crc_byte(crc_q, in_data_i.frame_byte);
      end else begin
        ovf_d = 1'b1;
      end
      if (in_data_i.frame_end) begin
        sel_low_d = in_data_i.low_priority;
        ok_d      = status_o.frame_ok;
        idx_d     = '0;
      end
    end

    if (cmd_i.copy_wr || cmd_i.crc_lo) begin
      idx_d = idx_q + IDX_W'(1);
    end

    if (cmd_i.crc_hi) begin
      if (sel_low_q) begin
        low_cnt_d = low_cnt_q + LOW_CW'(1);
      end else begin
        main_cnt_d = main_cnt_q + MAIN_CW'(1);
      end
    end

    // frame queued or dropped result, then restart the build
    if (cmd_i.post) begin
      out_valid_d          = 1'b1;
      out_d.result_kind    = ok_q ? RES_QUEUED : RES_DROPPED;
      out_d.tx_byte        = '0;
      out_d.from_low_queue = sel_low_q;
      out_d.last_of_run    = 1'b1;
      crc_d                = CRC_INIT;
      bcnt_d               = '0;
      ovf_d                = 1'b0;
    end

    if (cmd_i.take_tick) begin
      elapsed_d = el_next;
      rdy_d     = rdy_next;
      if (go) begin
        sel_low_d = go_low;
        idx_d     = '0;
        elapsed_d = '0;
        rdy_d     = 1'b0;
      end
    end

    // one transmit byte per transfer; pop the frame after its last byte
    if (cmd_i.send_out) begin
      out_valid_d          = 1'b1;
      out_d.result_kind    = RES_TX;
      out_d.tx_byte        = sel_low_q ? low_rdata : main_rdata;
      out_d.from_low_queue = sel_low_q;
      out_d.last_of_run    = status_o.send_last;
      if (status_o.send_last) begin
        if (sel_low_q) begin
          low_head_d = (low_head_q == LOW_SW'(LOW_DEPTH - 1)) ? '0 : low_head_q + LOW_SW'(1);
          low_cnt_d  = low_cnt_q - LOW_CW'(1);
        end else begin
          main_head_d = (main_head_q == MAIN_SW'(MAIN_DEPTH - 1)) ? '0
                                                                 : main_head_q + MAIN_SW'(1);
          main_cnt_d  = main_cnt_q - MAIN_CW'(1);
        end
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q      <= '0;
      ovf_q       <= 1'b0;
      crc_q       <= CRC_INIT;
      idx_q       <= '0;
      sel_low_q   <= 1'b0;
      ok_q        <= 1'b0;
      main_head_q <= '0;
      main_cnt_q  <= '0;
      low_head_q  <= '0;
      low_cnt_q   <= '0;
      elapsed_q   <= ELAPSED_MAX;
      rdy_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bcnt_q      <= bcnt_d;
      ovf_q       <= ovf_d;
      crc_q       <= crc_d;
      idx_q       <= idx_d;
      sel_low_q   <= sel_low_d;
      ok_q        <= ok_d;
      main_head_q <= main_head_d;
      main_cnt_q  <= main_cnt_d;
      low_head_q  <= low_head_d;
      low_cnt_q   <= low_cnt_d;
      elapsed_q   <= elapsed_d;
      rdy_q       <= rdy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.crc_hi) begin
      len_q[len_wr_idx] <= LEN_W'(bcnt_q + BCNT_W'(2));
    end
  end

  // build buffer
  mfcps_ram #(.WIDTH(8), .DEPTH(SLOT_BYTES)) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.take_byte && buf_room),
    .wr_addr_i (bcnt_q[IDX_W-1:0]),
    .wr_data_i (in_data_i.frame_byte),
    .rd_en_i   (cmd_i.copy_rd),
    .rd_addr_i (idx_q),
    .rd_data_o (buf_rdata)
  );

  // main queue frame store
  mfcps_ram #(.WIDTH(8), .DEPTH(MAIN_DEPTH * SLOT_BYTES)) u_main (
    .clk_i     (clk_i),
    .wr_en_i   (store_wr && !sel_low_q),
    .wr_addr_i (MAIN_AW'({main_tail, idx_q})),
    .wr_data_i (store_wdata),
    .rd_en_i   (cmd_i.send_rd && !sel_low_q),
    .rd_addr_i (MAIN_AW'({main_head_q, idx_q})),
    .rd_data_o (main_rdata)
  );

  // low priority frame store
  mfcps_ram #(.WIDTH(8), .DEPTH(LOW_DEPTH * SLOT_BYTES)) u_low (
    .clk_i     (clk_i),
    .wr_en_i   (store_wr && sel_low_q),
    .wr_addr_i (LOW_AW'({low_tail, idx_q})),
    .wr_data_i (store_wdata),
    .rd_en_i   (cmd_i.send_rd && sel_low_q),
    .rd_addr_i (LOW_AW'({low_head_q, idx_q})),
    .rd_data_o (low_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/mfcps_ctrl.sv @@
// controller state machine: sequences byte intake, frame copy, crc append and sends
// depends on mfcps_pkg
module mfcps_ctrl
  import mfcps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_ready_o,
  input  status_t  status_i,
  output cmd_t     cmd_o
);

  ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_BYTE) begin
            if (in_data_i.frame_end) begin
              state_d = status_i.frame_ok ? ST_COPY_RD : ST_POST;
            end
          end else if (status_i.tick_go) begin
            state_d = ST_SEND_RD;
          end
        end
      end
      ST_COPY_RD:  state_d = ST_COPY_WR;
      ST_COPY_WR:  state_d = status_i.copy_last ? ST_CRC_LO : ST_COPY_RD;
      ST_CRC_LO:   state_d = ST_CRC_HI;
      ST_CRC_HI:   state_d = ST_POST;
      ST_POST: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEND_RD:  state_d = ST_SEND_OUT;
      ST_SEND_OUT: begin
        if (status_i.out_free) begin
          state_d = status_i.send_last ? ST_IDLE : ST_SEND_RD;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.take_byte   = in_valid_i && (in_data_i.kind == KIND_BYTE);
        cmd_o.take_tick   = in_valid_i && (in_data_i.kind == KIND_TICK);
      end
      ST_COPY_RD:  cmd_o.copy_rd  = 1'b1;
      ST_COPY_WR:  cmd_o.copy_wr  = 1'b1;
      ST_CRC_LO:   cmd_o.crc_lo   = 1'b1;
      ST_CRC_HI:   cmd_o.crc_hi   = 1'b1;
      ST_POST:     cmd_o.post     = status_i.out_free;
      ST_SEND_RD:  cmd_o.send_rd  = 1'b1;
      ST_SEND_OUT: cmd_o.send_out = status_i.out_free;
      default:     cmd_o          = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/modbus_frame_crc_paced_sender_unit.sv @@
// Frame byte without frame_end: no result. Frame end: each stored byte is copied (read, then write),
// the crc low and high bytes are appended, then the queued result; a dropped frame goes straight to its result.
// Tick: may start a send, which reads each byte from the store and then gives it out, len+2 bytes.
// Input is taken only while no earlier item is at work; the output register frees the next item.
// Reset (async, active low): queues empty, crc 0xFFFF, elapsed 0xFFFF, gaps 1000 and 100.
// Stores hold no reset; depends on mfcps_pkg, mfcps_ctrl, mfcps_dp.
module modbus_frame_crc_paced_sender_unit
  import mfcps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] main_gap_q, main_gap_d;
  logic [15:0] low_gap_q, low_gap_d;
  logic        cfg_wr;
  cmd_t        cmd;
  status_t     status;

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    main_gap_d = main_gap_q;
    low_gap_d  = low_gap_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAIN_GAP: main_gap_d = pwdata[15:0];
        REG_LOW_GAP:  low_gap_d  = pwdata[15:0];
        default:      main_gap_d = main_gap_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_gap_q <= MAIN_GAP_RST;
      low_gap_q  <= LOW_GAP_RST;
    end else begin
      main_gap_q <= main_gap_d;
      low_gap_q  <= low_gap_d;
    end
  end

  assign prdata = {16'h0000, (paddr[2] == REG_LOW_GAP) ? low_gap_q : main_gap_q};

  // controller
  mfcps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  mfcps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .main_gap_i  (main_gap_q),
    .low_gap_i   (low_gap_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/mfcps_checker.sv @@
// port level checks for the paced modbus frame sender, bound to the top level
// depends on mfcps_pkg and modbus_frame_crc_paced_sender_unit
module mfcps_checker
  import mfcps_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // queued and dropped results are single, with a zero byte
  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == RES_QUEUED ||
                    out_data_o.result_kind == RES_DROPPED)
    |-> out_data_o.last_of_run && (out_data_o.tx_byte == 8'h00))
    else $error("malformed frame status result");

  // a mid-frame byte leaves the input open
  a_mid_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.kind == KIND_BYTE) && !in_data_i.frame_end
    |=> in_ready_o)
    else $error("input closed after a mid-frame byte");

  // input stays closed while a frame is still being sent
  a_send_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == RES_TX) && !out_data_o.last_of_run
    |-> !in_ready_o)
    else $error("input opened inside a send");

endmodule

bind modbus_frame_crc_paced_sender_unit mfcps_checker u_mfcps_checker (.*);

@@ sim/tb_top.sv @@
// testbench for the paced modbus frame sender: directed table, then random phases
// depends on mfcps_pkg and modbus_frame_crc_paced_sender_unit
module tb_top;
  import mfcps_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 300;
  localparam int HOLD_LONG   = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  modbus_frame_crc_paced_sender_unit DUT (.*);

  always #1 clk_i = ~clk_i;

  // sender model state
  logic [7:0]  main_store [MAIN_DEPTH][SLOT_BYTES];
  logic [7:0]  low_store  [LOW_DEPTH][SLOT_BYTES];
  int          main_len   [MAIN_DEPTH];
  int          low_len    [LOW_DEPTH];
  int          main_head, main_cnt, low_head, low_cnt;
  logic [7:0]  build_buf  [MAX_PAYLOAD];
  int          build_cnt;
  bit          build_ovf;
  logic [15:0] run_crc, elapsed, main_gap, low_gap;
  bit          send_armed;

  out_item_t   pending_q[$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_sends = 0;
  int          n_drops = 0;
  longint      cycles = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // modbus crc-16 over one byte, reflected form
  function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ 16'(b);
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
    return r;
  endfunction

  function automatic void model_reset();
    main_head = 0; main_cnt = 0; low_head = 0; low_cnt = 0;
    build_cnt = 0; build_ovf = 0; run_crc = CRC_INIT;
    elapsed = ELAPSED_MAX; send_armed = 0;
    main_gap = MAIN_GAP_RST; low_gap = LOW_GAP_RST;
  endfunction

  function automatic void push_result(result_kind_e k, logic [7:0] b, bit lo, bit last);
    out_item_t r;
    r.result_kind = k; r.tx_byte = b; r.from_low_queue = lo; r.last_of_run = last;
    pending_q.push_back(r);
  endfunction

  // front frame of one queue goes out byte by byte
  function automatic void emit_front(bit lo);
    int len;
    len = lo ? low_len[low_head] : main_len[main_head];
    for (int i = 0; i < len; i++)
      push_result(RES_TX, lo ? low_store[low_head][i] : main_store[main_head][i], lo,
                  i == len - 1);
    if (lo) begin
      low_head = (low_head + 1) % LOW_DEPTH; low_cnt--;
    end else begin
      main_head = (main_head + 1) % MAIN_DEPTH; main_cnt--;
    end
    send_armed = 0;
    elapsed = '0;
    n_sends++;
  endfunction

  function automatic void predict_item(in_item_t it);
    int slot;
    bit ok;
    if (it.kind == KIND_BYTE) begin
      if (build_cnt < MAX_PAYLOAD) begin
        build_buf[build_cnt] = it.frame_byte;
        build_cnt++;
        run_crc = crc16_update(run_crc, it.frame_byte);
      end else begin
        build_ovf = 1;
      end
      if (!it.frame_end) return;
      ok = !build_ovf && (it.low_priority ? low_cnt < LOW_DEPTH : main_cnt < MAIN_DEPTH);
      if (ok) begin
        if (it.low_priority) begin
          slot = (low_head + low_cnt) % LOW_DEPTH;
          for (int i = 0; i < build_cnt; i++) low_store[slot][i] = build_buf[i];
          low_store[slot][build_cnt] = run_crc[7:0];
          low_store[slot][build_cnt+1] = run_crc[15:8];
          low_len[slot] = build_cnt + 2;
          low_cnt++;
        end else begin
          slot = (main_head + main_cnt) % MAIN_DEPTH;
          for (int i = 0; i < build_cnt; i++) main_store[slot][i] = build_buf[i];
          main_store[slot][build_cnt] = run_crc[7:0];
          main_store[slot][build_cnt+1] = run_crc[15:8];
          main_len[slot] = build_cnt + 2;
          main_cnt++;
        end
      end else begin
        n_drops++;
      end
      push_result(ok ? RES_QUEUED : RES_DROPPED, 8'h00, it.low_priority, 1'b1);
      run_crc = CRC_INIT; build_cnt = 0; build_ovf = 0;
    end else begin
      if (elapsed != ELAPSED_MAX) elapsed++;
      if (main_cnt != 0) begin
        if (elapsed > main_gap) send_armed = 1;
        if (send_armed) emit_front(1'b0);
      end else if (low_cnt != 0) begin
        if (elapsed > low_gap) send_armed = 1;
        if (send_armed) emit_front(1'b1);
      end
    end
  endfunction

  // one input transfer; a typed expectation replaces the predicted one
  task automatic drive_item(in_item_t it, bit typed, result_kind_e tkind);
    int gap;
    int mark;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    mark = pending_q.size();
    predict_item(it);
    if (typed) begin
      while (pending_q.size() > mark) void'(pending_q.pop_back());
      push_result(tkind, 8'h00, it.low_priority, 1'b1);
    end
    n_items++;
  endtask

  task automatic drive_tick();
    in_item_t it;
    it = '0;
    it.kind = KIND_TICK;
    it.frame_byte = 8'($urandom());
    it.frame_end = 1'($urandom());
    it.low_priority = 1'($urandom());
    drive_item(it, 1'b0, RES_QUEUED);
  endtask

  // whole frame; rnd picks random bytes, else a pattern from seed
  task automatic drive_frame(int len, bit lo, logic [7:0] seed, bit rnd,
                             bit typed, result_kind_e tkind);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.kind = KIND_BYTE;
      it.frame_byte = rnd ? 8'($urandom()) : 8'(seed + i * 29);
      it.frame_end = (i == len - 1);
      it.low_priority = (i == len - 1) ? lo : 1'($urandom());
      drive_item(it, typed && (i == len - 1), tkind);
    end
  endtask

  // let the block run dry before touching registers
  task automatic wait_idle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // apb write then read back
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {1'b0, idx, 2'b00}; pwdata <= 32'(val);
    @(negedge clk_i) penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== val) begin
      $error("prdata: expected %0d, got %0d", val, prdata[15:0]);
      errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    if (idx == REG_MAIN_GAP) main_gap = val;
    else low_gap = val;
  endtask

  // directed table: kind, first byte, length, queue, typed result
  typedef struct {
    item_kind_e   kind;
    logic [7:0]   seed;
    int           len;
    bit           lo;
    bit           typed;
    result_kind_e tkind;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    '{KIND_TICK, 8'h00, 0,  0, 0, RES_QUEUED},   // nothing to send
    '{KIND_BYTE, 8'h00, 1,  0, 1, RES_QUEUED},
    '{KIND_BYTE, 8'hFF, 1,  1, 1, RES_QUEUED},
    '{KIND_BYTE, 8'h80, 3,  0, 0, RES_QUEUED},
    '{KIND_TICK, 8'h00, 0,  0, 0, RES_QUEUED},   // expired at reset: main goes
    '{KIND_TICK, 8'h00, 0,  0, 0, RES_QUEUED},   // gap not yet over
    '{KIND_BYTE, 8'hAA, 63, 0, 1, RES_DROPPED},  // one byte too long
    '{KIND_BYTE, 8'h55, 8,  0, 0, RES_QUEUED},
    '{KIND_BYTE, 8'h01, 4,  0, 0, RES_QUEUED},
    '{KIND_BYTE, 8'hFE, 2,  0, 0, RES_QUEUED},
    '{KIND_BYTE, 8'h7F, 1,  0, 0, RES_QUEUED},   // main now full
    '{KIND_BYTE, 8'h33, 1,  0, 1, RES_DROPPED},
    '{KIND_BYTE, 8'h44, 2,  1, 0, RES_QUEUED},
    '{KIND_BYTE, 8'hC3, 1,  1, 0, RES_QUEUED},   // low now full
    '{KIND_BYTE, 8'h3C, 1,  1, 1, RES_DROPPED},
    '{KIND_TICK, 8'h00, 0,  0, 0, RES_QUEUED}
  };

  // result checking and receiver stall draw
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("unexpected result kind %0d byte %02h", out_data_o.result_kind,
               out_data_o.tx_byte);
        errors++;
      end else begin
        out_item_t e;
        e = pending_q[0];
        pending_q.delete(0);
        if (out_data_o.result_kind !== e.result_kind) begin
          $error("result_kind: expected %0d, got %0d", e.result_kind, out_data_o.result_kind);
          errors++;
        end
        if (out_data_o.tx_byte !== e.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", e.tx_byte, out_data_o.tx_byte);
          errors++;
        end
        if (out_data_o.from_low_queue !== e.from_low_queue) begin
          $error("from_low_queue: expected %0d, got %0d", e.from_low_queue,
                 out_data_o.from_low_queue);
          errors++;
        end
        if (out_data_o.last_of_run !== e.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", e.last_of_run, out_data_o.last_of_run);
          errors++;
        end
      end
      hold_left = rx_calm ? 0 : $urandom_range(0, 14);
    end
  end

  // receiver ready, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LONG;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // random phase: mostly well-formed frames, some ticks, a few oversize frames
  task automatic random_phase(int quota);
    int stop;
    int len;
    stop = n_items + quota;
    while (n_items < stop) begin
      if ($urandom_range(0, 19) == 0) tx_calm = ~tx_calm;
      if ($urandom_range(0, 19) == 0) rx_calm = ~rx_calm;
      if ($urandom_range(0, 9) < 4) begin
        repeat ($urandom_range(1, 3)) drive_tick();
      end else begin
        case ($urandom_range(0, 31))
          0:       len = $urandom_range(63, 66);
          1, 2:    len = $urandom_range(7, 62);
          default: len = $urandom_range(1, 6);
        endcase
        drive_frame(len, 1'($urandom()), 8'h00, 1'b1, 1'b0, RES_QUEUED);
      end
    end
  endtask

  // main sequence
  initial begin
    model_reset();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == KIND_TICK) drive_tick();
      else drive_frame(dir_tab[r].len, dir_tab[r].lo, dir_tab[r].seed, 1'b0,
                       dir_tab[r].typed, dir_tab[r].tkind);
    end
    wait_idle();

    // zero gaps drain both queues; long receiver hold fills the block
    write_reg(REG_MAIN_GAP, 16'd0);
    write_reg(REG_LOW_GAP, 16'd0);
    hold_req = 1'b1;
    tx_calm = 1'b1;
    random_phase(16);
    tx_calm = 1'b0;
    wait_idle();

    write_reg(REG_MAIN_GAP, 16'd2);
    write_reg(REG_LOW_GAP, 16'd5);
    random_phase(14);
    wait_idle();

    write_reg(REG_MAIN_GAP, 16'hFFFF);
    write_reg(REG_LOW_GAP, 16'd0);
    random_phase(12);
    wait_idle();

    write_reg(REG_MAIN_GAP, 16'd0);
    write_reg(REG_LOW_GAP, 16'hFFFF);
    random_phase(12);
    wait_idle();

    write_reg(REG_MAIN_GAP, 16'd1);
    write_reg(REG_LOW_GAP, 16'd3);
    random_phase(16);
    wait_idle();

    $display("covered %0d input transfers, %0d results, %0d frames sent, %0d dropped",
             n_items, n_results, n_sends, n_drops);
    $display("gap settings from 0 to 65535, long output stall, oversize and full queues");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
